// ----- hdl/q24_alu_pkg.sv -----
// Package for the Q24.8 fixed-point ALU: mode codes, widths and the stage payload type.
// Used by every module of the block; depends on nothing.
`default_nettype none
package q24_alu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DIV_STAGES = NUM_W;

    localparam logic [4:0] MODE_ADD        = 5'd0;
    localparam logic [4:0] MODE_SUB        = 5'd1;
    localparam logic [4:0] MODE_MUL        = 5'd2;
    localparam logic [4:0] MODE_DIV        = 5'd3;
    localparam logic [4:0] MODE_GT         = 5'd4;
    localparam logic [4:0] MODE_GE         = 5'd5;
    localparam logic [4:0] MODE_LT         = 5'd6;
    localparam logic [4:0] MODE_LE         = 5'd7;
    localparam logic [4:0] MODE_EQ         = 5'd8;
    localparam logic [4:0] MODE_NE         = 5'd9;
    localparam logic [4:0] MODE_MIN        = 5'd10;
    localparam logic [4:0] MODE_MAX        = 5'd11;
    localparam logic [4:0] MODE_INC        = 5'd12;
    localparam logic [4:0] MODE_DEC        = 5'd13;
    localparam logic [4:0] MODE_FROM_INT   = 5'd14;
    localparam logic [4:0] MODE_TO_INT     = 5'd15;
    localparam logic [4:0] MODE_FROM_FLOAT = 5'd16;
    localparam logic [4:0] MODE_TO_FLOAT   = 5'd17;

    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] EXP_BIAS    = 8'd127;

    // Payload that travels down the divider chain alongside the other results.
    typedef struct packed {
        logic [4:0]        mode;
        logic [DATA_W-1:0] res;
        logic              flag;
        logic              dz;
        logic              qneg;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
    } pipe_t;

endpackage
`default_nettype wire

// ----- hdl/q24_alu_front.sv -----
// Front end of the Q24.8 ALU: two register stages that work out every mode but divide
// and set up the divider operands. Depends on q24_alu_pkg.
`default_nettype none
module q24_alu_front (
    input  wire logic                   aclk,
    input  wire logic                   en1,
    input  wire logic                   en2,
    input  wire logic [4:0]             mode,
    input  wire logic signed [31:0]     operand_a,
    input  wire logic signed [31:0]     operand_b,
    output q24_alu_pkg::pipe_t          out_reg
);
    import q24_alu_pkg::*;

    logic [4:0]         mode_reg;
    logic [31:0]        res1_reg, res1_next;
    logic               flag1_reg, flag1_next;
    logic signed [63:0] prod_reg;
    logic [31:0]        mag_reg, mag_next;
    logic [4:0]         p_reg, p_next;
    logic               sgn_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [31:0]        den_reg;
    logic               qneg_reg, dz_reg;

    // First stage: simple modes, float to fixed, and operand magnitudes.
    always_comb begin
        logic [7:0]         e;
        logic [23:0]        m;
        logic signed [9:0]  k;
        logic signed [31:0] sm;
        logic [4:0]         n;
        logic signed [31:0] ff;
        logic [31:0]        abs_a, t;
        e  = operand_a[30:23];
        m  = {(e != 8'd0), operand_a[22:0]};
        k  = (e != 8'd0) ? ($signed({2'b00, e}) - 10'sd142) : -10'sd141;
        sm = operand_a[31] ? -$signed({8'd0, m}) : $signed({8'd0, m});
        n  = 5'd0;
        ff = 32'sd0;
        if (e == EXP_SPECIAL || m == 24'd0) begin
            ff = 32'sd0;
        end else if (k >= 10'sd0) begin
            if (k < 10'sd32) begin
                ff = sm <<< k[4:0];
            end
        end else if (k > -10'sd26) begin
            n  = 5'((-k));
            ff = (sm + $signed(32'd1 << (n - 5'd1))) >>> n;
        end
        abs_a = operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
        t     = abs_a >> FRAC_BITS;
        mag_next = abs_a;
        p_next = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (abs_a[i]) begin
                p_next = 5'(i);
            end
        end
        res1_next  = 32'd0;
        flag1_next = 1'b0;
        case (mode)
            MODE_ADD:        res1_next = 32'(operand_a + operand_b);
            MODE_SUB:        res1_next = 32'(operand_a - operand_b);
            MODE_GT:         flag1_next = operand_a > operand_b;
            MODE_GE:         flag1_next = operand_a >= operand_b;
            MODE_LT:         flag1_next = operand_a < operand_b;
            MODE_LE:         flag1_next = operand_a <= operand_b;
            MODE_EQ:         flag1_next = operand_a == operand_b;
            MODE_NE:         flag1_next = operand_a != operand_b;
            MODE_MIN:        res1_next = (operand_a < operand_b) ? operand_a : operand_b;
            MODE_MAX:        res1_next = (operand_a > operand_b) ? operand_a : operand_b;
            MODE_INC:        res1_next = 32'(operand_a + 32'sd1);
            MODE_DEC:        res1_next = 32'(operand_a - 32'sd1);
            MODE_FROM_INT:   res1_next = 32'(operand_a) << FRAC_BITS;
            MODE_TO_INT:     res1_next = operand_a[31] ? 32'(-t) : t;
            MODE_FROM_FLOAT: res1_next = ff;
            default:         res1_next = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            mode_reg  <= mode;
            res1_reg  <= res1_next;
            flag1_reg <= flag1_next;
            prod_reg  <= 64'(operand_a) * 64'(operand_b);
            mag_reg   <= mag_next;
            p_reg     <= p_next;
            sgn_reg   <= operand_a[31];
            num_reg   <= {8'd0, mag_next} << FRAC_BITS;
            den_reg   <= operand_b[31] ? 32'(-operand_b) : 32'(operand_b);
            qneg_reg  <= operand_a[31] ^ operand_b[31];
            dz_reg    <= (mode == MODE_DIV) && (operand_b == 32'sd0);
        end
    end

    // Second stage: product scaling and fixed to float rounding.
    pipe_t out_next;
    always_comb begin
        logic [24:0] mant;
        logic [4:0]  r, pp;
        logic [31:0] rmask, rrem, half;
        logic [31:0] fl;
        r     = 5'd0;
        rmask = 32'd0;
        rrem  = 32'd0;
        half  = 32'd0;
        pp    = p_reg;
        if (p_reg <= 5'd23) begin
            mant = 25'(mag_reg << (5'd23 - p_reg));
        end else begin
            r     = p_reg - 5'd23;
            rmask = (32'd1 << r) - 32'd1;
            rrem  = mag_reg & rmask;
            half  = 32'd1 << (r - 5'd1);
            mant  = 25'(mag_reg >> r);
            if (rrem > half || (rrem == half && mant[0])) begin
                mant = mant + 25'd1;
            end
            if (mant[24]) begin
                mant = mant >> 1;
                pp   = p_reg + 5'd1;
            end
        end
        fl = (mag_reg == 32'd0) ? 32'd0 :
             {sgn_reg, 8'({3'd0, pp} + EXP_BIAS - 8'(FRAC_BITS)), mant[22:0]};
        out_next      = '0;
        out_next.mode = mode_reg;
        out_next.flag = flag1_reg;
        out_next.dz   = dz_reg;
        out_next.qneg = qneg_reg;
        out_next.num  = num_reg;
        out_next.den  = den_reg;
        case (mode_reg)
            MODE_MUL:      out_next.res = prod_reg[DATA_W+FRAC_BITS-1:FRAC_BITS];
            MODE_TO_FLOAT: out_next.res = fl;
            default:       out_next.res = res1_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/q24_alu_div_stage.sv -----
// One restoring-division step of the Q24.8 ALU divider chain: one quotient bit per stage.
// Depends on q24_alu_pkg.
`default_nettype none
module q24_alu_div_stage (
    input  wire logic            aclk,
    input  wire logic            en,
    input  q24_alu_pkg::pipe_t   in_pipe,
    output q24_alu_pkg::pipe_t   out_reg
);
    import q24_alu_pkg::*;

    pipe_t       out_next;
    logic [32:0] trial;
    logic        ge;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        trial    = {in_pipe.rem, in_pipe.num[NUM_W-1]};
        ge       = trial >= {1'b0, in_pipe.den};
        out_next = in_pipe;
        out_next.rem = ge ? 32'(trial - {1'b0, in_pipe.den}) : trial[31:0];
        out_next.num = in_pipe.num << 1;
        out_next.quo = {in_pipe.quo[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/q24_8_fixed_point_alu_core.sv -----
// Q24.8 fixed-point ALU, fully pipelined: two front stages, forty divider stages, one output stage.
// Every mode passes through all of these stages; one beat is accepted per cycle when the output is taken.
// Throughput is set by the one-bit-per-stage divider chain, which never recirculates.
// Each stage holds its beat when the stage after it is full and stalled; bubbles are squeezed out.
// aresetn (synchronous, active low) clears only the stage valid bits; payload is not reset.
// Depends on q24_alu_pkg, q24_alu_front and q24_alu_div_stage.
`default_nettype none
module q24_8_fixed_point_alu_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [4:0]         s_mode,
    input  wire logic signed [31:0] s_operand_a,
    input  wire logic signed [31:0] s_operand_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_result,
    output logic                    m_flag,
    output logic                    m_div_by_zero
);
    import q24_alu_pkg::*;

    localparam int N_STAGES = DIV_STAGES + 3;

    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] rdy;
    pipe_t               chain [0:DIV_STAGES];

    // Per-stage ready: a stage loads when it is empty or its successor moves on.
    always_comb begin
        rdy[N_STAGES-1] = !vld_reg[N_STAGES-1] || m_ready;
        for (int i = N_STAGES - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end
    assign s_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < N_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    q24_alu_front u_front (
        .aclk      (aclk),
        .en1       (rdy[0]),
        .en2       (rdy[1]),
        .mode      (s_mode),
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .out_reg   (chain[0])
    );

    // Divider chain, one quotient bit per stage.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        q24_alu_div_stage u_stage (
            .aclk    (aclk),
            .en      (rdy[g+2]),
            .in_pipe (chain[g]),
            .out_reg (chain[g+1])
        );
    end

    // Output stage: sign the quotient and pick the result for the mode.
    pipe_t       last;
    logic [31:0] q;
    logic [31:0] res_next;
    logic [31:0] res_reg;
    logic        flag_reg, dz_reg;

    always_comb begin
        last = chain[DIV_STAGES];
        q    = last.qneg ? 32'(-last.quo) : last.quo;
        if (last.mode == MODE_DIV) begin
            res_next = last.dz ? 32'd0 : q;
        end else begin
            res_next = last.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[N_STAGES-1]) begin
            res_reg  <= res_next;
            flag_reg <= last.flag;
            dz_reg   <= last.dz;
        end
    end

    assign m_valid       = vld_reg[N_STAGES-1];
    assign m_result      = $signed(res_reg);
    assign m_flag        = flag_reg;
    assign m_div_by_zero = dz_reg;

    // A divide by zero always returns zero.
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_by_zero |-> m_result == 32'sd0)
        else $error("divide by zero gave a non-zero result");

    // A compare that holds carries a zero result and no divide error.
    a_flag_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flag |-> m_result == 32'sd0 && !m_div_by_zero)
        else $error("compare beat carries a stray result");

    // With the output being taken, the whole chain moves and input is always ready.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output was ready");

    // A beat entering an empty pipeline does not reach the output early.
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg == '0 |=> !m_valid)
        else $error("output valid without a beat in flight");

endmodule
`default_nettype wire

// ----- dv/q24_alu_checker.sv -----
// Checker for the Q24.8 fixed-point ALU: watches both channels, predicts each result beat
// from the accepted input beat and compares field by field. Depends on q24_alu_pkg.
`timescale 1ns / 1ps
module q24_alu_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [4:0]         s_mode,
    input  wire logic signed [31:0] s_operand_a,
    input  wire logic signed [31:0] s_operand_b,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [31:0] m_result,
    input  wire logic               m_flag,
    input  wire logic               m_div_by_zero,
    output int                      fail_count,
    output int                      pending
);
    import q24_alu_pkg::*;

    typedef struct packed {
        logic [31:0] result;
        logic        flag;
        logic        dz;
    } alu_out_t;

    alu_out_t outcome_q[$];

    assign pending = outcome_q.size();

    // Floor of v divided by 2^n.
    function automatic longint floor_div_pow2(longint v, int n);
        return v >>> n;
    endfunction

    // IEEE single to Q24.8, rounding half up, with zero for specials and tiny values.
    function automatic logic [31:0] single_to_q(logic [31:0] bits);
        logic [7:0] e;
        longint     m;
        int         k;
        e = bits[30:23];
        m = longint'(bits[22:0]);
        if (e == EXP_SPECIAL) return 32'd0;
        if (e != 0) begin
            m = m | 64'h80_0000;
            k = int'(e) - 150 + FRAC_BITS;
        end else begin
            k = -149 + FRAC_BITS;
        end
        if (m == 0) return 32'd0;
        if (bits[31]) m = -m;
        if (k >= 0) begin
            if (k >= 32) return 32'd0;
            return 32'(m << k);
        end
        if (-k >= 26) return 32'd0;
        return 32'(floor_div_pow2(m + (64'sd1 <<< (-k - 1)), -k));
    endfunction

    // Q24.8 to IEEE single, round to nearest even.
    function automatic logic [31:0] q_to_single(longint a);
        logic        sgn;
        logic [63:0] mag, mant, rem, half;
        int          p, r;
        sgn = a < 0;
        mag = sgn ? -a : a;
        if (mag == 0) return 32'd0;
        p = 0;
        while ((mag >> (p + 1)) != 0) p++;
        if (p <= 23) begin
            mant = mag << (23 - p);
        end else begin
            r = p - 23;
            rem = mag & ((64'd1 << r) - 1);
            half = 64'd1 << (r - 1);
            mant = mag >> r;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == (64'd1 << 24)) begin
                mant = mant >> 1;
                p++;
            end
        end
        return {sgn, 8'(p - FRAC_BITS + 127), mant[22:0]};
    endfunction

    function automatic alu_out_t alu_outcome(logic [4:0] mode, logic signed [31:0] opa,
                                             logic signed [31:0] opb);
        alu_out_t o;
        longint   a, b;
        a = opa;
        b = opb;
        o = '0;
        case (mode)
            MODE_ADD:        o.result = 32'(a + b);
            MODE_SUB:        o.result = 32'(a - b);
            MODE_MUL:        o.result = 32'(floor_div_pow2(a * b, FRAC_BITS));
            MODE_DIV: begin
                if (b == 0) o.dz = 1'b1;
                else        o.result = 32'((a * 256) / b);
            end
            MODE_GT:         o.flag = a > b;
            MODE_GE:         o.flag = a >= b;
            MODE_LT:         o.flag = a < b;
            MODE_LE:         o.flag = a <= b;
            MODE_EQ:         o.flag = a == b;
            MODE_NE:         o.flag = a != b;
            MODE_MIN:        o.result = 32'(a < b ? a : b);
            MODE_MAX:        o.result = 32'(a > b ? a : b);
            MODE_INC:        o.result = 32'(a + 1);
            MODE_DEC:        o.result = 32'(a - 1);
            MODE_FROM_INT:   o.result = 32'(a << FRAC_BITS);
            MODE_TO_INT:     o.result = 32'(a >= 0 ? (a >>> FRAC_BITS) : -((-a) >>> FRAC_BITS));
            MODE_FROM_FLOAT: o.result = single_to_q(opa);
            MODE_TO_FLOAT:   o.result = q_to_single(a);
            default: ;
        endcase
        return o;
    endfunction

    // Predict on each accepted input beat and compare each accepted result beat.
    always @(posedge aclk) begin
        alu_out_t want;
        bit       bad;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                outcome_q.push_back(alu_outcome(s_mode, s_operand_a, s_operand_b));
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    fail_count <= fail_count + 1;
                end else begin
                    want = outcome_q.pop_front();
                    bad  = 1'b0;
                    if (m_result !== want.result) begin
                        $error("result: expected %h, got %h", want.result, m_result);
                        bad = 1'b1;
                    end
                    if (m_flag !== want.flag) begin
                        $error("flag: expected %b, got %b", want.flag, m_flag);
                        bad = 1'b1;
                    end
                    if (m_div_by_zero !== want.dz) begin
                        $error("div_by_zero: expected %b, got %b", want.dz, m_div_by_zero);
                        bad = 1'b1;
                    end
                    if (bad) fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

// ----- dv/tb_q24_8_fixed_point_alu_core.sv -----
// Testbench top for the Q24.8 fixed-point ALU: clock, reset, stimulus and verdict.
// Depends on q24_alu_pkg, q24_8_fixed_point_alu_core and q24_alu_checker.
`timescale 1ns / 1ps
module tb_q24_8_fixed_point_alu_core;
    import q24_alu_pkg::*;

    localparam int LATENCY     = 43;
    localparam int STALL_LIMIT = 5000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [4:0]         s_mode = '0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_result;
    logic               m_flag;
    logic               m_div_by_zero;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct = 23;
    int                 recv_idle_pct = 87;
    bit                 hold_recv = 1'b0;
    int                 quiet_cycles = 0;

    always #2 aclk = ~aclk;

    q24_8_fixed_point_alu_core u_top (.*);

    q24_alu_checker u_checker (.*);

    // Receiver readiness, with an optional long hold-off.
    always @(posedge aclk) begin
        if (hold_recv) m_ready <= 1'b0;
        else           m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no accepted beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offer one beat, with a random gap first, and wait for it to be accepted.
    task automatic send_beat(logic [4:0] mode, logic [31:0] opa, logic [31:0] opb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_operand_a <= opa;
        s_operand_b <= opb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return 32'($urandom_range(600)) - 32'd300;
            3: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
            4: return {1'b0, 8'($urandom_range(100, 170)), 23'($urandom)} | ($urandom << 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [4:0]  mode;
        logic [31:0] opa, opb;
        for (int i = 0; i < n; i++) begin
            mode = ($urandom_range(19) == 0) ? 5'($urandom_range(18, 31))
                                              : 5'($urandom_range(17));
            opa = pick_operand();
            opb = ($urandom_range(9) == 0) ? 32'd0 : pick_operand();
            if (mode >= MODE_GT && mode <= MODE_MAX && $urandom_range(3) == 0) opb = opa;
            send_beat(mode, opa, opb);
        end
    endtask

    initial begin
        logic [31:0] edge_vals[6];
        edge_vals = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h100, 32'h1};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every mode, extreme operands, divide by zero, float specials.
        for (int m = 0; m < 18; m++) send_beat(5'(m), edge_vals[m % 6], edge_vals[(m + 2) % 6]);
        send_beat(MODE_DIV, 32'h7FFF_FFFF, 32'h0);
        send_beat(MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_beat(MODE_FROM_FLOAT, 32'h7F80_0000, 32'h0);
        send_beat(MODE_FROM_FLOAT, 32'h8000_0000, 32'h0);
        send_beat(MODE_FROM_FLOAT, 32'h0000_0001, 32'h0);
        send_beat(MODE_FROM_FLOAT, 32'h3B80_0000, 32'h0);
        send_beat(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        random_phase(400);

        // Long receiver hold-off while the sender keeps offering beats.
        hold_recv = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_recv = 1'b0;
            end
            random_phase(100);
        join
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);

        send_idle_pct = 87;
        recv_idle_pct = 23;
        random_phase(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(400);
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) $display("simulation ok");
        else                                 $display("simulation failed");
        $finish;
    end

endmodule
